[sv/psp_pkg.sv]
package psp_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_PROG_DESC = 3'd1;
  localparam logic [2:0] PH_ENTRIES   = 3'd2;
  localparam logic [2:0] PH_ES_DESC   = 3'd3;
  localparam logic [2:0] PH_SKIP      = 3'd4;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_DESC  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  localparam logic [12:0] IDX_MAX = 13'd8191;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id_value;
    logic [7:0]  strm_type;
    logic [12:0] pid;
    logic [11:0] info_length;
    logic [7:0]  desc_byte;
    logic        desc_level;
    logic [4:0]  version;
    logic        cni_flag;
    logic [12:0] pcr_pid;
    logic [1:0]  status;
    logic        crc_ok;
  } out_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[sv/psp_if.sv]
interface psp_in_if;
  import psp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psp_out_if;
  import psp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psp_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/psp_crc.sv]
module psp_crc
  import psp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        clear,
  input  logic [7:0]  data_byte,
  input  logic [12:0] byte_index,
  output logic [31:0] crc_next,
  output logic [31:0] tail_next
);

  logic [31:0] crc_r;
  logic [31:0] tail_r;

  always_comb begin
    crc_next  = (byte_index >= 13'd4) ? crc_byte(crc_r, tail_r[31:24]) : crc_r;
    tail_next = {tail_r[23:0], data_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      tail_r <= '0;
    end else if (step) begin
      if (clear) begin
        crc_r  <= CRC_INIT;
        tail_r <= '0;
      end else begin
        crc_r  <= crc_next;
        tail_r <= tail_next;
      end
    end
  end

endmodule

[sv/psp_parse.sv]
module psp_parse
  import psp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        table_kind,
  input  in_item_t    item,
  output logic [12:0] byte_index,
  input  logic [31:0] crc_next,
  input  logic [31:0] tail_next,
  output logic        produced,
  output out_item_t   result
);

  logic [12:0] idx_r;
  logic [11:0] sec_len_r, sec_len_nxt;
  logic [15:0] hdr_id_r, hdr_id_nxt;
  logic [5:0]  hdr_ver_r, hdr_ver_nxt;
  logic [12:0] pcr_r, pcr_nxt;
  logic [11:0] pil_r, pil_nxt;
  logic [39:0] rec_r, rec_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [11:0] esl_r, esl_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [7:0]  b;
  logic [2:0]  rsize;
  logic [11:0] pil_full;
  logic [11:0] el;

  assign byte_index = idx_r;
  assign b = item.data_byte;
  assign rsize = table_kind ? 3'd5 : 3'd4;
  assign pil_full = {pil_r[11:8], b};
  assign el = {rec_nxt[11:8], rec_nxt[7:0]};

  always_comb begin
    sec_len_nxt = sec_len_r;
    hdr_id_nxt  = hdr_id_r;
    hdr_ver_nxt = hdr_ver_r;
    pcr_nxt     = pcr_r;
    pil_nxt     = pil_r;
    rec_nxt     = rec_r;
    pos_nxt     = pos_r;
    esl_nxt     = esl_r;
    phase_nxt   = phase_r;
    err_nxt     = err_r;
    produced    = 1'b0;
    result      = '0;
    if (item.last_byte) begin
      produced            = 1'b1;
      result.kind         = KIND_END;
      result.id_value     = hdr_id_r;
      result.version      = hdr_ver_r[5:1];
      result.cni_flag     = hdr_ver_r[0];
      result.pcr_pid      = pcr_r;
      if ({1'b0, idx_r} + 14'd1 < (table_kind ? 14'd16 : 14'd12)) begin
        result.status = ST_SHORT;
      end else if (err_r != ST_OK) begin
        result.status = ST_CORRUPT;
      end else if ({1'b0, idx_r} != {2'b0, sec_len_r} + 14'd2) begin
        result.status = ST_CORRUPT;
      end else begin
        result.status = ST_OK;
      end
      result.crc_ok = (idx_r >= 13'd7) && (crc_next == tail_next);
    end else begin
      case (phase_r)
        PH_HEADER: begin
          case (idx_r)
            13'd0: begin
              if (b != (table_kind ? 8'h02 : 8'h00)) begin
                err_nxt = ST_CORRUPT;
                phase_nxt = PH_SKIP;
              end
            end
            13'd1: sec_len_nxt = {b[3:0], 8'd0};
            13'd2: sec_len_nxt = {sec_len_r[11:8], b};
            13'd3: hdr_id_nxt = {b, 8'd0};
            13'd4: hdr_id_nxt = {hdr_id_r[15:8], b};
            13'd5: hdr_ver_nxt = b[5:0];
            13'd7: if (!table_kind) phase_nxt = PH_ENTRIES;
            13'd8: pcr_nxt = {b[4:0], 8'd0};
            13'd9: pcr_nxt = {pcr_r[12:8], b};
            13'd10: pil_nxt = {b[3:0], 8'd0};
            13'd11: begin
              pil_nxt = pil_full;
              if ({1'b0, pil_full} + 13'd13 > {1'b0, sec_len_r}) begin
                err_nxt = ST_CORRUPT;
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = (pil_full != 12'd0) ? PH_PROG_DESC : PH_ENTRIES;
              end
            end
            default: ;
          endcase
        end
        PH_PROG_DESC: begin
          produced = 1'b1;
          result.kind = KIND_DESC;
          result.desc_byte = b;
          pil_nxt = pil_r - 12'd1;
          if (pil_nxt == 12'd0) phase_nxt = PH_ENTRIES;
        end
        PH_ENTRIES: begin
          if (pos_r == 3'd0 &&
              {1'b0, idx_r} + {11'd0, rsize} + 14'd1 > {2'b0, sec_len_r}) begin
            phase_nxt = PH_SKIP;
          end else begin
            rec_nxt = {rec_r[31:0], b};
            pos_nxt = pos_r + 3'd1;
            if (pos_nxt >= rsize) begin
              pos_nxt = 3'd0;
              if (!table_kind) begin
                produced = 1'b1;
                result.kind = KIND_ENTRY;
                result.id_value = rec_nxt[31:16];
                result.pid = rec_nxt[12:0];
              end else if ({1'b0, idx_r} + 14'd2 + {2'b0, el} > {2'b0, sec_len_r}) begin
                err_nxt = ST_CORRUPT;
                phase_nxt = PH_SKIP;
              end else begin
                produced = 1'b1;
                result.kind = KIND_ENTRY;
                result.strm_type = rec_nxt[39:32];
                result.pid = rec_nxt[28:16];
                result.info_length = el;
                esl_nxt = el;
                if (el != 12'd0) phase_nxt = PH_ES_DESC;
              end
            end
          end
        end
        PH_ES_DESC: begin
          produced = 1'b1;
          result.kind = KIND_DESC;
          result.desc_byte = b;
          result.desc_level = 1'b1;
          esl_nxt = esl_r - 12'd1;
          if (esl_nxt == 12'd0) phase_nxt = PH_ENTRIES;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      idx_r     <= '0;
      sec_len_r <= '0;
      hdr_id_r  <= '0;
      hdr_ver_r <= '0;
      pcr_r     <= '0;
      pil_r     <= '0;
      rec_r     <= '0;
      pos_r     <= '0;
      esl_r     <= '0;
      phase_r   <= PH_HEADER;
      err_r     <= ST_OK;
    end else if (step) begin
      if (idx_r != IDX_MAX) idx_r <= idx_r + 13'd1;
      sec_len_r <= sec_len_nxt;
      hdr_id_r  <= hdr_id_nxt;
      hdr_ver_r <= hdr_ver_nxt;
      pcr_r     <= pcr_nxt;
      pil_r     <= pil_nxt;
      rec_r     <= rec_nxt;
      pos_r     <= pos_nxt;
      esl_r     <= esl_nxt;
      phase_r   <= phase_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

[sv/psi_section_parser_core.sv]
// A result is registered and appears on out_ in the cycle after its input byte is accepted.
// Throughput: one byte per cycle; in_ready holds low only while a result waits
// on a stalled output.
// Reset: synchronous active-low rst_n clears parser state, CRC (to all ones)
// and the table_kind register (PAT).
module psi_section_parser_core
  import psp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  psp_in_if.sink     in_ch,
  psp_out_if.source  out_ch,
  psp_cfg_if.sink    cfg_ch
);

  logic        kind_r;
  logic        step;
  logic [12:0] byte_index;
  logic [31:0] crc_next;
  logic [31:0] tail_next;
  logic        produced;
  out_item_t   result;
  logic        out_valid_r;
  out_item_t   out_data_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign step         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      kind_r <= cfg_ch.data;
    end
  end

  psp_crc u_crc (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .clear      (in_ch.data.last_byte),
    .data_byte  (in_ch.data.data_byte),
    .byte_index (byte_index),
    .crc_next   (crc_next),
    .tail_next  (tail_next)
  );

  psp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .table_kind (kind_r),
    .item       (in_ch.data),
    .byte_index (byte_index),
    .crc_next   (crc_next),
    .tail_next  (tail_next),
    .produced   (produced),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= step && produced;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produced) out_data_r <= result;
  end

endmodule

[verif/psp_checker.sv]
`timescale 1ns / 100ps
module psp_checker
  import psp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  psp_in_if.sink in_mon,
  psp_out_if.sink out_mon,
  psp_cfg_if.sink cfg_mon,
  output int fail_count,
  output int pending
);

  logic        kind_pmt;
  logic [12:0] pos;
  logic [11:0] sec_len;
  logic [15:0] hdr_id;
  logic [5:0]  hdr_ver;
  logic [12:0] pcr;
  logic [11:0] prog_left;
  logic [39:0] rec;
  logic [2:0]  rec_pos;
  logic [11:0] es_left;
  logic [2:0]  phase;
  logic [1:0]  err;
  logic [31:0] crc;
  logic [31:0] tail;
  out_item_t   expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [31:0] crc_step(input logic [31:0] c0, input logic [7:0] b);
    logic [31:0] c;
    c = c0 ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
    return c;
  endfunction

  task automatic clear_section();
    pos = 0; sec_len = 0; hdr_id = 0; hdr_ver = 0; pcr = 0; prog_left = 0;
    rec = 0; rec_pos = 0; es_left = 0; phase = PH_HEADER; err = ST_OK;
    crc = 32'hFFFFFFFF; tail = 0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    logic got;
    logic [2:0] size;
    logic [11:0] el;
    r = '0;
    got = 0;
    if (pos >= 4) crc = crc_step(crc, tail[31:24]);
    tail = {tail[23:0], b};
    if (last) begin
      r.kind = KIND_END;
      r.id_value = hdr_id;
      r.version = hdr_ver[5:1];
      r.cni_flag = hdr_ver[0];
      r.pcr_pid = pcr;
      if (int'(pos) + 1 < (kind_pmt ? 16 : 12)) r.status = ST_SHORT;
      else if (err != ST_OK) r.status = ST_CORRUPT;
      else if (int'(pos) != int'(sec_len) + 2) r.status = ST_CORRUPT;
      else r.status = ST_OK;
      r.crc_ok = (int'(pos) + 1 >= 8) && (crc == tail);
      expected_q.push_back(r);
      clear_section();
      return;
    end
    case (phase)
      PH_HEADER: begin
        case (pos)
          0: if (b != (kind_pmt ? 8'h02 : 8'h00)) begin
            err = ST_CORRUPT; phase = PH_SKIP;
          end
          1: sec_len = {b[3:0], 8'h00};
          2: sec_len[7:0] = b;
          3: hdr_id = {b, 8'h00};
          4: hdr_id[7:0] = b;
          5: hdr_ver = b[5:0];
          7: if (!kind_pmt) phase = PH_ENTRIES;
          8: pcr = {b[4:0], 8'h00};
          9: pcr[7:0] = b;
          10: prog_left = {b[3:0], 8'h00};
          11: begin
            prog_left[7:0] = b;
            if (int'(prog_left) + 13 > int'(sec_len)) begin
              err = ST_CORRUPT; phase = PH_SKIP;
            end else phase = (prog_left != 0) ? PH_PROG_DESC : PH_ENTRIES;
          end
          default: ;
        endcase
      end
      PH_PROG_DESC: begin
        r.kind = KIND_DESC; r.desc_byte = b; r.desc_level = 0; got = 1;
        prog_left = prog_left - 12'd1;
        if (prog_left == 0) phase = PH_ENTRIES;
      end
      PH_ENTRIES: begin
        size = kind_pmt ? 3'd5 : 3'd4;
        if (rec_pos == 0 && int'(pos) + int'(size) + 1 > int'(sec_len)) phase = PH_SKIP;
        else begin
          rec = {rec[31:0], b};
          rec_pos++;
          if (rec_pos >= size) begin
            rec_pos = 0;
            if (!kind_pmt) begin
              r.kind = KIND_ENTRY; r.id_value = rec[31:16]; r.pid = rec[12:0]; got = 1;
            end else begin
              el = rec[11:0];
              if (int'(pos) + 2 + int'(el) > int'(sec_len)) begin
                err = ST_CORRUPT; phase = PH_SKIP;
              end else begin
                r.kind = KIND_ENTRY; r.strm_type = rec[39:32]; r.pid = rec[28:16];
                r.info_length = el; got = 1;
                es_left = el;
                if (el != 0) phase = PH_ES_DESC;
              end
            end
          end
        end
      end
      PH_ES_DESC: begin
        r.kind = KIND_DESC; r.desc_byte = b; r.desc_level = 1; got = 1;
        es_left = es_left - 12'd1;
        if (es_left == 0) phase = PH_ENTRIES;
      end
      default: ;
    endcase
    if (pos != IDX_MAX) pos++;
    if (got) expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kind_pmt <= 0;
      clear_section();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_mon.data);
          fail_count <= fail_count + 1;
        end else begin
          if (out_mon.data !== expected_q[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time, expected_q[0],
                     out_mon.data);
            fail_count <= fail_count + 1;
          end
          void'(expected_q.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.data.data_byte, in_mon.data.last_byte);
      if (cfg_mon.valid && cfg_mon.ready) kind_pmt <= cfg_mon.data;
    end
  end

endmodule

[verif/psi_section_parser_core_test.sv]
`timescale 1ns / 100ps
module psi_section_parser_core_test;
  import psp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   rx_idle_off;
  bit   rx_hold;
  bit   tx_idle_off;
  bit   cur_pmt;
  logic [7:0] sect[$];

  psp_in_if  in_ch();
  psp_out_if out_ch();
  psp_cfg_if cfg_ch();

  psi_section_parser_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  psp_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    int n;
    bit held;
    out_ch.ready = 0;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold && !held) begin
        held = 1;
        out_ch.ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ch.ready <= 1;
      end else if (!rx_idle_off && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_ch.ready <= 0;
        repeat (n) @(negedge clk);
        out_ch.ready <= 1;
      end else out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!tx_idle_off && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_in();
    in_ch.valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_section();
    for (int i = 0; i < sect.size(); i++) send_byte(sect[i], i == sect.size() - 1);
  endtask

  task automatic write_kind(input logic k);
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.data <= k;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
    cur_pmt = k;
  endtask

  function automatic logic [31:0] section_crc();
    logic [31:0] c;
    c = 32'hFFFFFFFF;
    foreach (sect[i]) begin
      c = c ^ {sect[i], 24'd0};
      for (int j = 0; j < 8; j++) c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
    end
    return c;
  endfunction

  task automatic build_section(input bit corrupt_ok);
    int entries;
    int plen;
    int elen;
    int slen;
    logic [31:0] c;
    sect.delete();
    sect.push_back(cur_pmt ? 8'h02 : 8'h00);
    sect.push_back(8'h00);
    sect.push_back(8'h00);
    repeat (3) sect.push_back(8'($urandom));
    sect.push_back(8'($urandom));
    sect.push_back(8'($urandom));
    if (cur_pmt) begin
      sect.push_back(8'($urandom));
      sect.push_back(8'($urandom));
      plen = $urandom_range(0, 3);
      sect.push_back({4'($urandom_range(0, 15)), 4'h0});
      sect.push_back(8'(plen));
      repeat (plen) sect.push_back(8'($urandom));
      entries = $urandom_range(0, 3);
      repeat (entries) begin
        elen = $urandom_range(0, 3);
        sect.push_back(8'($urandom));
        sect.push_back(8'($urandom));
        sect.push_back(8'($urandom));
        sect.push_back({4'($urandom_range(0, 15)), 4'h0});
        sect.push_back(8'(elen));
        repeat (elen) sect.push_back(8'($urandom));
      end
    end else begin
      entries = $urandom_range(0, 5);
      repeat (entries * 4) sect.push_back(8'($urandom));
    end
    slen = sect.size() + 4 - 3;
    sect[1] = {4'($urandom_range(0, 15)), 4'(slen >> 8)};
    sect[2] = slen[7:0];
    c = section_crc();
    if (corrupt_ok && $urandom_range(0, 3) == 0) c ^= 32'h1 << $urandom_range(0, 31);
    for (int i = 3; i >= 0; i--) sect.push_back(c[i*8 +: 8]);
    if (corrupt_ok && $urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: sect[$urandom_range(0, sect.size() - 1)] = 8'($urandom);
        1: void'(sect.pop_back());
        default: sect.push_back(8'($urandom));
      endcase
    end
  endtask

  initial begin
    int items;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    rx_idle_off = 0;
    rx_hold = 0;
    tx_idle_off = 0;
    cur_pmt = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    build_section(0); send_section();
    sect = '{8'h00, 8'h00, 8'h0D, 8'h12, 8'h34, 8'hFF, 8'h00, 8'h00, 8'hFF};
    send_section();
    write_kind(1);
    build_section(0); send_section();
    sect = '{8'h02, 8'hFF, 8'hFF, 8'hAA, 8'h55, 8'hC1, 8'h00, 8'h00,
             8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_section();
    sect = '{8'h00, 8'h80};
    send_section();

    rx_hold = 1;
    repeat (3) begin
      build_section(0); send_section();
    end
    stop_in();

    items = 0;
    for (int k = 0; items < 600; k++) begin
      if (k % 15 == 0) write_kind(1'($urandom_range(0, 1)));
      if (items > 480) begin
        tx_idle_off = 1;
        rx_idle_off = 1;
      end
      if ($urandom_range(0, 9) == 0) begin
        sect.delete();
        repeat ($urandom_range(1, 20)) sect.push_back(8'($urandom));
      end else build_section(1);
      send_section();
      items += sect.size();
    end
    stop_in();
    for (int i = 0; i < 1000 && pending != 0; i++) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
